FILE: hdl/sdr_pkg.sv
`default_nettype none
package sdr_pkg;

  // Register indexes, byte address 4*index
  localparam logic [2:0] REG_MIN_DELAY    = 3'd0;
  localparam logic [2:0] REG_START_MULT   = 3'd1;
  localparam logic [2:0] REG_ACCEL_FRAC   = 3'd2;
  localparam logic [2:0] REG_TOTAL_STEPS  = 3'd3;
  localparam logic [2:0] REG_ACCEL_DIS    = 3'd4;

  // Register reset values
  localparam logic [31:0] MIN_DELAY_RST   = 32'd4096;
  localparam logic [7:0]  START_MULT_RST  = 8'd4;
  localparam logic [15:0] ACCEL_FRAC_RST  = 16'd655;
  localparam logic [31:0] TOTAL_STEPS_RST = 32'd0;
  localparam logic [31:0] START_DELAY_RST = 32'd16384;

  // 15 ms in Q20.12
  localparam logic [31:0] LONG_LIMIT = 32'd61440;

  // Register values as seen by the ramp core
  typedef struct packed {
    logic [31:0] min_delay;
    logic [31:0] start_delay;   // min_delay * start_multiplier, saturated
    logic [15:0] accel_fraction;
    logic [31:0] total_steps;
    logic        accel_disable;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/sdr_regs.sv
`default_nettype none
module sdr_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sdr_pkg::cfg_t     cfg_o
);

  logic [31:0] min_delay_q;
  logic [7:0]  start_mult_q;
  logic [15:0] accel_frac_q;
  logic [31:0] total_steps_q;
  logic        accel_dis_q;
  logic [31:0] start_delay_q, start_delay_d;
  logic [39:0] start_prod;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  // Start delay product uses the value being written and the held partner
  always_comb begin
    if (idx == sdr_pkg::REG_MIN_DELAY) begin
      start_prod = {8'd0, pwdata} * {32'd0, start_mult_q};
    end else begin
      start_prod = {8'd0, min_delay_q} * {32'd0, pwdata[7:0]};
    end
    start_delay_d = (|start_prod[39:32]) ? 32'hFFFF_FFFF : start_prod[31:0];
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_delay_q   <= sdr_pkg::MIN_DELAY_RST;
      start_mult_q  <= sdr_pkg::START_MULT_RST;
      accel_frac_q  <= sdr_pkg::ACCEL_FRAC_RST;
      total_steps_q <= sdr_pkg::TOTAL_STEPS_RST;
      accel_dis_q   <= 1'b0;
      start_delay_q <= sdr_pkg::START_DELAY_RST;
    end else if (wr_en) begin
      unique case (idx)
        sdr_pkg::REG_MIN_DELAY: begin
          min_delay_q   <= pwdata;
          start_delay_q <= start_delay_d;
        end
        sdr_pkg::REG_START_MULT: begin
          start_mult_q  <= pwdata[7:0];
          start_delay_q <= start_delay_d;
        end
        sdr_pkg::REG_ACCEL_FRAC:  accel_frac_q  <= pwdata[15:0];
        sdr_pkg::REG_TOTAL_STEPS: total_steps_q <= pwdata;
        sdr_pkg::REG_ACCEL_DIS:   accel_dis_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      sdr_pkg::REG_MIN_DELAY:   prdata = min_delay_q;
      sdr_pkg::REG_START_MULT:  prdata = {24'd0, start_mult_q};
      sdr_pkg::REG_ACCEL_FRAC:  prdata = {16'd0, accel_frac_q};
      sdr_pkg::REG_TOTAL_STEPS: prdata = total_steps_q;
      sdr_pkg::REG_ACCEL_DIS:   prdata = {31'd0, accel_dis_q};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o.min_delay      = min_delay_q;
  assign cfg_o.start_delay    = start_delay_q;
  assign cfg_o.accel_fraction = accel_frac_q;
  assign cfg_o.total_steps    = total_steps_q;
  assign cfg_o.accel_disable  = accel_dis_q;

endmodule
`default_nettype wire

FILE: hdl/sdr_core.sv
`default_nettype none
module sdr_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sdr_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          in_new_move_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        out_delay_o,
  output logic               out_long_o,
  output logic [1:0]         out_phase_o
);

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_e;

  // Input stage
  logic        s1_valid_q;
  logic        s1_new_q;
  logic        s1_adv;

  // Move state
  phase_e      ph_q, ph_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] ds_q, ds_d;
  logic [31:0] ld_q;

  // Result register
  logic        out_valid_q;
  logic [31:0] out_delay_q;
  logic        out_long_q;
  logic [1:0]  out_phase_q;

  // Datapath
  phase_e      ph_b;
  logic [31:0] cnt_b, ds_b, ld_b;
  logic [47:0] prod;
  logic [31:0] change;
  logic [31:0] shrunk;
  logic [32:0] sum;
  logic [31:0] grown;
  logic [31:0] delay_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Apply a new move ahead of the step
  always_comb begin
    if (s1_new_q) begin
      ph_b  = PH_ACCEL;
      cnt_b = 32'd1;
      ds_b  = 32'd0;
      ld_b  = cfg_i.start_delay;
    end else begin
      ph_b  = ph_q;
      cnt_b = cnt_q;
      ds_b  = ds_q;
      ld_b  = ld_q;
    end
  end

  // One change per step, shared by shrink and growth
  assign prod   = {16'd0, ld_b} * {32'd0, cfg_i.accel_fraction};
  assign change = prod[47:16];
  assign shrunk = ld_b - change;
  assign sum    = {1'b0, ld_b} + {1'b0, change};
  assign grown  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  // Step the ramp
  always_comb begin
    ph_d    = ph_b;
    cnt_d   = cnt_b;
    ds_d    = ds_b;
    delay_d = cfg_i.min_delay;
    if (!cfg_i.accel_disable) begin
      unique case (ph_b)
        PH_ACCEL: begin
          if (shrunk <= cfg_i.min_delay) begin
            ph_d = PH_CRUISE;
            ds_d = (cfg_i.total_steps > cnt_b) ? cfg_i.total_steps - cnt_b : 32'd0;
          end else if (cnt_b > {1'b0, cfg_i.total_steps[31:1]}) begin
            ph_d    = PH_DECEL;
            delay_d = grown;
          end else begin
            delay_d = shrunk;
          end
        end
        PH_CRUISE: begin
          if (cnt_b >= ds_b) begin
            ph_d    = PH_DECEL;
            delay_d = grown;
          end
        end
        default: begin
          ph_d    = PH_DECEL;
          delay_d = grown;
        end
      endcase
      if (cnt_b != 32'hFFFF_FFFF) begin
        cnt_d = cnt_b + 32'd1;
      end
    end
  end

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_new_q <= in_new_move_i;
    end
  end

  // Move state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_ACCEL;
      cnt_q       <= 32'd1;
      ds_q        <= 32'd0;
      ld_q        <= sdr_pkg::START_DELAY_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        ph_q  <= ph_d;
        cnt_q <= cnt_d;
        ds_q  <= ds_d;
        ld_q  <= delay_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_delay_q <= delay_d;
      out_long_q  <= delay_d > sdr_pkg::LONG_LIMIT;
      out_phase_q <= ph_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_delay_o = out_delay_q;
  assign out_long_o  = out_long_q;
  assign out_phase_o = out_phase_q;

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 32'd0) else $error("step count reached zero");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_phase_q != 2'd3) else $error("phase code three produced");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q) else $error("advanced request left no result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire

FILE: hdl/stepper_step_delay_ramp_top.sv
// Trapezoidal stepper ramp: one delay per step request.
// Slave stream: each request carries new_move in tdata bit 0; a set bit
// restarts the move (accelerate, step one, start delay) before the step.
// Master stream: per request one result with step_delay, long_delay and
// the phase left after the step.
// APB port: min_delay, start_multiplier, accel_fraction, total_steps and
// accel_disable at byte addresses 0, 4, 8, 12, 16; pready is always high.
// Write registers only while no request is in flight.
// A request is registered in the input stage, then in the result
// register once that is empty or being read. Throughput: one request per
// cycle while results are taken, set by the loop from the previous delay
// via the 32x16 multiplier and subtract/compare into the delay register.
// Reset: registers take their defaults, the move state is accelerate at
// step one with a 4 ms start delay, and both stages are empty.
// Stall: a waiting result is held; one more request is taken into the
// input stage, then tready drops until the result is taken.
`default_nettype none
module stepper_step_delay_ramp_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Slave stream; tdata: [0] new_move, [7:1] zero
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,
  // Master stream; tdata: [31:0] step_delay, [32] long_delay, [34:33] phase,
  // [39:35] zero
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [39:0]       m_axis_tdata_o,
  // APB configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  sdr_pkg::cfg_t cfg;
  logic [31:0]   delay;
  logic          long_dly;
  logic [1:0]    phase;

  sdr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_new_move_i (s_axis_tdata_i[0]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_delay_o   (delay),
    .out_long_o    (long_dly),
    .out_phase_o   (phase)
  );

  // Pack the result
  assign m_axis_tdata_o = {5'd0, phase, long_dly, delay};

endmodule
`default_nettype wire
